// ===== rtl/bba_pkg.sv =====
// Package: request/result types, status codes and helper functions for the buddy allocator.
`timescale 1ns / 1ps
package bba_pkg;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [31:0] request_bytes;
        logic [31:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_offset;
    } res_t;

    // ceil(log2(v)) for v >= 1; 32 for v == 0
    function automatic logic [5:0] ceil_log2(input logic [31:0] v);
        logic [31:0] m;
        logic [5:0]  k;
        m = v - 32'd1;
        k = 6'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (m[i])
                k = 6'(i + 1);
        end
        return k;
    endfunction

endpackage

// ===== rtl/bba_store.sv =====
// Block order and used-mark memory with registered read; the clearing pass is driven from the top level.
`timescale 1ns / 1ps
module bba_store #(
    parameter int LEVELS = 10
) (
    input  logic              clk,
    input  logic [LEVELS-1:0] raddr,
    output logic [3:0]        rorder,
    output logic              rused,
    input  logic              we,
    input  logic [LEVELS-1:0] waddr,
    input  logic [3:0]        worder,
    input  logic              wused
);
    logic [4:0] mem [2**LEVELS];
    logic [4:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= {worder, wused};
        rdata_reg <= mem[raddr];
    end

    assign rorder = rdata_reg[4:1];
    assign rused  = rdata_reg[0];
endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Top level: buddy allocator sequencer over a block order/used memory.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  request | start, busy, req               | taken when start && !busy
//  result  | done, res                      | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data | taken when valid && ready
//
// Every request ends in a one-cycle done state; a request that resolves at once (zero or
// oversized allocate, out-of-range free) goes straight from idle to the done state.
// Each memory access runs read, wait, check, once per block head visited.
// Allocate: scan block heads (up to 2^LEVELS heads), then split level by level, then mark.
// Free: walk heads up to the target, then merge level by level until a buddy differs or the root.
// After reset a clearing pass over all 2^LEVELS entries runs with busy high.
// The result strobe cannot be held off; busy drops in the cycle after done.
`timescale 1ns / 1ps
module buddy_block_allocator #(
    parameter int LEVELS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bba_pkg::req_t req,
    output logic          done,
    output bba_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data
);
    localparam int NB = 2**LEVELS;
    localparam logic [3:0] TOP = 4'(LEVELS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;  // scan: read issued
    localparam logic [3:0] S_SCK  = 4'd3;  // scan: check data
    localparam logic [3:0] S_SPL  = 4'd4;  // split step
    localparam logic [3:0] S_HRD  = 4'd5;  // head walk read
    localparam logic [3:0] S_HCK  = 4'd6;
    localparam logic [3:0] S_MRD  = 4'd7;  // merge: write head, read buddy
    localparam logic [3:0] S_MCK  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;
    localparam logic [3:0] S_WT   = 4'd10; // wait for read data

    logic [3:0]        state_reg, state_next;
    logic [LEVELS:0]   p_reg, p_next;          // scan/walk pointer (may reach NB)
    logic [LEVELS:0]   best_reg, best_next;    // NB means none
    logic [3:0]        bord_reg, bord_next;    // order of best / current block
    logic [3:0]        need_reg, need_next;
    logic [LEVELS-1:0] pos_reg, pos_next;
    logic [1:0]        st_reg, st_next;
    logic [31:0]       off_reg, off_next;
    logic [4:0]        mbl_reg;
    logic [3:0]        ret_reg, ret_next;      // state after read wait

    logic [LEVELS-1:0] raddr;
    logic [3:0]        rorder;
    logic              rused;
    logic              we;
    logic [LEVELS-1:0] waddr;
    logic [3:0]        worder;
    logic              wused;

    bba_store #(.LEVELS(LEVELS)) u_store (
        .clk(clk), .raddr(raddr), .rorder(rorder), .rused(rused),
        .we(we), .waddr(waddr), .worder(worder), .wused(wused)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign done      = (state_reg == S_DONE);
    assign res.status       = st_reg;
    assign res.block_offset = off_reg;

    // request decode
    logic [5:0]  k;
    logic [5:0]  needw;
    logic [63:0] idxw;
    logic [LEVELS:0] step;
    logic [LEVELS:0] bud;
    logic [63:0] offw;
    always_comb
    begin
        k     = bba_pkg::ceil_log2(req.request_bytes);
        needw = (k > {1'b0, mbl_reg}) ? k - {1'b0, mbl_reg} : 6'd0;
        idxw  = {32'd0, req.free_offset} >> mbl_reg;
        step  = (LEVELS+1)'(1) << rorder;
        bud   = {1'b0, pos_reg} ^ ((LEVELS+1)'(1) << bord_reg);
        offw  = 64'(best_reg[LEVELS-1:0]) << mbl_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        best_next  = best_reg;
        bord_next  = bord_reg;
        need_next  = need_reg;
        pos_next   = pos_reg;
        st_next    = st_reg;
        off_next   = off_reg;
        ret_next   = ret_reg;
        raddr      = p_reg[LEVELS-1:0];
        we         = 1'b0;
        waddr      = p_reg[LEVELS-1:0];
        worder     = 4'd0;
        wused      = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                // clear each entry; entry 0 holds the whole pool
                we     = 1'b1;
                worder = (p_reg == '0) ? TOP : 4'd0;
                p_next = p_reg + 1'b1;
                if (p_reg == (LEVELS+1)'(NB - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    p_next    = '0;
                    best_next = (LEVELS+1)'(NB);
                    off_next  = 32'd0;
                    if (req.operation == bba_pkg::OP_ALLOC)
                    begin
                        need_next = needw[3:0];
                        st_next   = bba_pkg::ST_OOM;
                        if (req.request_bytes == 32'd0 || needw > 6'(LEVELS))
                            state_next = S_DONE;
                        else
                            state_next = S_SRD;
                    end
                    else if (idxw >= 64'(NB))
                    begin
                        st_next    = bba_pkg::ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        st_next    = bba_pkg::ST_FREED;
                        pos_next   = idxw[LEVELS-1:0];
                        state_next = S_HRD;
                    end
                end
            end
            S_SRD:
            begin
                raddr      = p_reg[LEVELS-1:0];
                ret_next   = S_SCK;
                state_next = S_WT;
            end
            S_WT:
            begin
                state_next = ret_reg;
            end
            S_SCK:
            begin
                if (!rused && rorder >= need_reg &&
                    (best_reg[LEVELS] || bord_reg > rorder))
                begin
                    best_next = p_reg;
                    bord_next = rorder;
                end
                p_next = p_reg + step;
                if ((p_reg + step) >= (LEVELS+1)'(NB))
                begin
                    if (best_reg[LEVELS] && !(!rused && rorder >= need_reg))
                        state_next = S_DONE;
                    else
                        state_next = S_SPL;
                end
                else
                    state_next = S_SRD;
            end
            S_SPL:
            begin
                if (bord_reg > need_reg)
                begin
                    // split: write the upper half's head
                    we        = 1'b1;
                    waddr     = best_reg[LEVELS-1:0] + (LEVELS)'(1 << (bord_reg - 4'd1));
                    worder    = bord_reg - 4'd1;
                    bord_next = bord_reg - 4'd1;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = best_reg[LEVELS-1:0];
                    worder     = bord_reg;
                    wused      = 1'b1;
                    st_next    = bba_pkg::ST_ALLOC;
                    off_next   = offw[31:0];
                    state_next = S_DONE;
                end
            end
            S_HRD:
            begin
                raddr      = p_reg[LEVELS-1:0];
                ret_next   = S_HCK;
                state_next = S_WT;
            end
            S_HCK:
            begin
                if (p_reg[LEVELS-1:0] == pos_reg)
                begin
                    // head found: clear used mark, begin merging
                    we         = 1'b1;
                    waddr      = pos_reg;
                    worder     = rorder;
                    bord_next  = rorder;
                    state_next = S_MRD;
                end
                else if ((p_reg + step) > {1'b0, pos_reg})
                    state_next = S_DONE;
                else
                begin
                    p_next     = p_reg + step;
                    state_next = S_HRD;
                end
            end
            S_MRD:
            begin
                // write the current head (free, at its current order), then probe its buddy
                we     = 1'b1;
                waddr  = pos_reg;
                worder = bord_reg;
                if (bord_reg >= TOP || bud[LEVELS])
                    state_next = S_DONE;
                else
                begin
                    raddr      = bud[LEVELS-1:0];
                    p_next     = bud;
                    ret_next   = S_MCK;
                    state_next = S_WT;
                end
            end
            S_MCK:
            begin
                if (rused || rorder != bord_reg)
                    state_next = S_DONE;
                else if (bud[LEVELS-1:0] > pos_reg)
                begin
                    // absorb right buddy: drop its head, raise left on the next cycle
                    we         = 1'b1;
                    waddr      = bud[LEVELS-1:0];
                    worder     = 4'd0;
                    bord_next  = bord_reg + 4'd1;
                    state_next = S_MRD;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg;
                    worder     = 4'd0;
                    pos_next   = bud[LEVELS-1:0];
                    bord_next  = bord_reg + 4'd1;
                    state_next = S_MRD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            p_reg     <= '0;
            mbl_reg   <= 5'd4;
            ret_reg   <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            ret_reg   <= ret_next;
            if (cfg_valid && cfg_ready)
                mbl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        bord_reg <= bord_next;
        need_reg <= need_next;
        pos_reg  <= pos_next;
        st_reg   <= st_next;
        off_reg  <= off_next;
    end
endmodule

// ===== tb/tb.sv =====
// Testbench for buddy_block_allocator: random and directed requests checked against a predictor.
`timescale 1ns / 1ps
module tb;
    import bba_pkg::*;

    localparam int LV = 10;
    localparam int NB = 1 << LV;

    // Mirror of the block state; predicts one result per accepted request.
    class alloc_scoreboard;
        bit [3:0] order_mem[NB];
        bit       used_mem[NB];
        bit [4:0] min_log2;
        res_t     pending[$];
        int       last_idx;

        function new();
            foreach (order_mem[i])
            begin
                order_mem[i] = 4'd0;
                used_mem[i] = 1'b0;
            end
            order_mem[0] = 4'(LV);
            min_log2 = 5'd4;
        endfunction

        function void set_min(bit [4:0] v);
            min_log2 = v;
        endfunction

        function bit at_head(int idx);
            int p;
            p = 0;
            while (p < idx)
                p += 1 << order_mem[p];
            return p == idx;
        endfunction

        // Predict the result of one request and update the mirrored state.
        function void note_request(req_t r);
            res_t    e;
            int      k, need, p, best, nb, lo, hi;
            bit [63:0] idx;
            e.status = ST_OOM;
            e.block_offset = '0;
            last_idx = -1;
            if (r.operation == OP_ALLOC)
            begin
                if (r.request_bytes != 0)
                begin
                    k = 0;
                    while (k < 32 && (64'd1 << k) < {32'd0, r.request_bytes})
                        k++;
                    need = (k > int'(min_log2)) ? k - int'(min_log2) : 0;
                    if (need <= LV)
                    begin
                        p = 0;
                        best = NB;
                        while (p < NB)
                        begin
                            if (!used_mem[p] && order_mem[p] >= need &&
                                (best == NB || order_mem[best] > order_mem[p]))
                                best = p;
                            p += 1 << order_mem[p];
                        end
                        if (best != NB)
                        begin
                            while (order_mem[best] > need && order_mem[best] > 0)
                            begin
                                order_mem[best] = order_mem[best] - 4'd1;
                                order_mem[best + (1 << order_mem[best])] = order_mem[best];
                            end
                            used_mem[best] = 1'b1;
                            e.status = ST_ALLOC;
                            idx = 64'(best) << min_log2;
                            e.block_offset = idx[31:0];
                            last_idx = best;
                        end
                    end
                end
            end
            else
            begin
                idx = {32'd0, r.free_offset} >> min_log2;
                if (idx >= 64'(NB))
                    e.status = ST_RANGE;
                else
                begin
                    e.status = ST_FREED;
                    p = int'(idx);
                    if (at_head(p))
                    begin
                        used_mem[p] = 1'b0;
                        // merge with equal, free buddies toward the root
                        while (order_mem[p] < LV)
                        begin
                            nb = p ^ (1 << order_mem[p]);
                            if (used_mem[nb] || order_mem[nb] != order_mem[p])
                                break;
                            lo = (p < nb) ? p : nb;
                            hi = (p < nb) ? nb : p;
                            order_mem[lo] = order_mem[p] + 4'd1;
                            order_mem[hi] = 4'd0;
                            p = lo;
                        end
                    end
                end
            end
            pending.push_back(e);
        endfunction

        // Compare against the oldest expectation; empty string means a match.
        function string check(res_t got);
            res_t e;
            if (pending.size() == 0)
                return $sformatf("result with nothing expected: status %0d offset %h",
                                 got.status, got.block_offset);
            e = pending.pop_front();
            if (got.status !== e.status)
                return $sformatf("status %0d, expected %0d", got.status, e.status);
            if (got.block_offset !== e.block_offset)
                return $sformatf("offset %h, expected %h", got.block_offset, e.block_offset);
            return "";
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       done;
    res_t       res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    alloc_scoreboard sb;
    int          mismatches;
    int          idle_pct;
    int unsigned held[$];

    buddy_block_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .res      (res),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Results cannot be held off: check every strobe as it goes by.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && done)
        begin
            msg = sb.check(res);
            if (msg != "")
                report(msg);
        end
    end

    // Drive one request; returns at a falling edge after it has been taken.
    task automatic send(input req_t r);
        bit b;
        int gap;
        gap = (int'($urandom_range(99)) < idle_pct) ? int'($urandom_range(1, 6)) : 0;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        req = r;
        do
        begin
            b = busy;
            @(posedge clk);
            if (!b)
            begin
                sb.note_request(r);
                if (sb.last_idx >= 0)
                    held.push_back(sb.last_idx);
            end
            @(negedge clk);
        end
        while (b);
    endtask

    task automatic alloc(input logic [31:0] bytes);
        req_t r;
        r.operation = OP_ALLOC;
        r.request_bytes = bytes;
        r.free_offset = $urandom;
        send(r);
    endtask

    task automatic release_at(input logic [31:0] offs);
        req_t r;
        r.operation = OP_FREE;
        r.request_bytes = $urandom;
        r.free_offset = offs;
        send(r);
    endtask

    // Free one held block, picked at random, at its offset under the current setting.
    task automatic release_held();
        int          i;
        logic [63:0] o;
        i = $urandom_range(held.size() - 1);
        o = 64'(held[i]) << sb.min_log2;
        held.delete(i);
        release_at(o[31:0]);
    endtask

    // Write the minimum block size once the block has drained.
    task automatic set_min_block(input logic [4:0] v);
        bit b;
        start = 1'b0;
        while (sb.pending.size() != 0 || busy)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do
        begin
            b = cfg_ready;
            @(posedge clk);
            @(negedge clk);
        end
        while (!b);
        cfg_valid = 1'b0;
        sb.set_min(v);
    endtask

    task automatic random_item();
        int          pick, lg;
        logic [63:0] o;
        pick = $urandom_range(99);
        lg = int'(sb.min_log2) + int'($urandom_range(LV + 1));
        if (pick < 50 || held.size() == 0)
        begin
            // mostly small sizes, a few huge or fully random
            if (pick < 4)
                alloc($urandom);
            else if (lg > 31)
                alloc(32'hFFFF_FFFF);
            else if ($urandom_range(3) == 0)
                alloc(32'd1 << lg);
            else
                alloc(32'($urandom_range((32'd1 << lg) - 1, 0)) + 32'd1);
        end
        else if (pick < 88)
            release_held();
        else if (pick < 94)
            release_at($urandom);
        else
        begin
            // offset inside the pool, often not at a block head
            o = 64'($urandom_range(NB - 1)) << sb.min_log2;
            release_at(o[31:0] | ($urandom & 32'h7));
        end
    endtask

    initial
    begin
        logic [4:0] settings[6];
        int         modes[4];
        sb = new();
        mismatches = 0;
        idle_pct = 0;
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = 5'd4;
        settings = '{5'd4, 5'd0, 5'd16, 5'd31, 5'd7, 5'd2};
        modes = '{0, 45, 0, 34};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: edge sizes, out-of-range and off-head frees, whole pool.
        set_min_block(5'd4);
        alloc(32'd0);
        alloc(32'hFFFF_FFFF);
        alloc(32'd16385);
        alloc(32'd16384);
        alloc(32'd1);
        release_at(32'd0);
        alloc(32'd1);
        alloc(32'd16);
        alloc(32'd17);
        alloc(32'd100);
        release_at(32'hFFFF_FFFF);
        release_at(32'd16384);
        release_at(32'd24);
        release_at(32'd8);
        release_at(32'd16);
        release_at(32'd16);
        while (held.size() != 0)
            release_held();
        alloc(32'd16384);
        release_at(32'd5);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_min_block(ph == 0 ? 5'($urandom) : settings[ph]);
            for (int m = 0; m < 4; m++)
            begin
                idle_pct = modes[m];
                repeat (23) random_item();
            end
        end
        start = 1'b0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
